FILE: hdl/angle_bias_kalman_update_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the angle/bias Kalman update core
// Each macro expects i_clk and i_rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef ANGLE_BIAS_KALMAN_UPDATE_CORE_MACROS_SVH
`define ANGLE_BIAS_KALMAN_UPDATE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ABKF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ABKF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/abkf_pkg.sv
// ----------------------------------------------------------------------------
// abkf_pkg
// Widths, constants, codes and saturation helpers of the Kalman update core.
// ----------------------------------------------------------------------------
package abkf_pkg;

    localparam int ANG_W   = 25;
    localparam int RATE_W  = 28;
    localparam int DT_W    = 17;
    localparam int NOISE_W = 31;
    localparam int COV_W   = 48;
    localparam int BIAS_W  = 29;
    localparam int OBIAS_W = 28;
    localparam int K_W     = 33;
    localparam int MB_W    = 48;
    localparam int MR_W    = 52;
    localparam int WX_W    = 31;
    localparam int Y_W     = 27;
    localparam int DEN_W   = 49;
    localparam int CIDX_W  = 2;

    localparam int ANG_HALF = 11796480;
    localparam int ANG_FULL = 23592960;
    localparam int BIAS_MAX = 131072000;
    localparam int DT_MAX   = 65536;

    localparam logic [NOISE_W-1:0] QA_RST = NOISE_W'(1073742);
    localparam logic [NOISE_W-1:0] QB_RST = NOISE_W'(3221225);
    localparam logic [NOISE_W-1:0] R_RST  = NOISE_W'(32212255);

    localparam logic [CIDX_W-1:0] CFG_ANGLE_NOISE = CIDX_W'(0);
    localparam logic [CIDX_W-1:0] CFG_BIAS_NOISE  = CIDX_W'(1);
    localparam logic [CIDX_W-1:0] CFG_MEAS_NOISE  = CIDX_W'(2);

    typedef struct packed {
        logic start;
        logic shr30;
    } t_mul_req;

    function automatic logic signed [COV_W-1:0] sat48(input logic signed [MR_W-1:0] x);
        logic signed [COV_W-1:0] r;
        if (!x[MR_W-1] && (|x[MR_W-2:COV_W-1])) begin
            r = {1'b0, {(COV_W-1){1'b1}}};
        end else if (x[MR_W-1] && !(&x[MR_W-2:COV_W-1])) begin
            r = {1'b1, {(COV_W-1){1'b0}}};
        end else begin
            r = x[COV_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [BIAS_W-1:0] clamp_bias(input logic signed [MR_W-1:0] x);
        logic signed [BIAS_W-1:0] r;
        if (x > MR_W'(BIAS_MAX)) begin
            r = BIAS_W'(BIAS_MAX);
        end else if (x < -MR_W'(BIAS_MAX)) begin
            r = -BIAS_W'(BIAS_MAX);
        end else begin
            r = x[BIAS_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: hdl/abkf_if.sv
// ----------------------------------------------------------------------------
// abkf_if
// Handshake channels of the Kalman update core: input, result, register write.
// ----------------------------------------------------------------------------
interface abkf_in_if import abkf_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [ANG_W-1:0]  measured_angle;
    logic signed [RATE_W-1:0] rate;
    logic [DT_W-1:0]          time_step;

    modport source (output valid, output measured_angle, output rate, output time_step,
                    input ready);
    modport sink   (input valid, input measured_angle, input rate, input time_step,
                    output ready);
endinterface

interface abkf_out_if import abkf_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [ANG_W-1:0]   angle_estimate;
    logic signed [OBIAS_W-1:0] bias_estimate;

    modport source (output valid, output angle_estimate, output bias_estimate, input ready);
    modport sink   (input valid, input angle_estimate, input bias_estimate, output ready);
endinterface

interface abkf_cfg_if import abkf_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CIDX_W-1:0]  index;
    logic [NOISE_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/angle_bias_kalman_update_core.sv
// ----------------------------------------------------------------------------
// angle_bias_kalman_update_core
// Two-state angle/bias Kalman filter step with one shared multiplier and a
// serial divider under a small sequencer.
// ----------------------------------------------------------------------------
// Each item takes ten multiplications through the shared multiplier, two
// angle wraps of five compare-subtract steps each, a step for the
// innovation variance, two 30-step gain divisions in the radix-2 divider
// and a final step to load the result. When the innovation variance is not
// positive the divisions are skipped. The input is not ready while an item
// is in work; a finished result waits in the output register and the next
// item is accepted meanwhile, but the following result then waits until the
// first one has left. Register writes are taken at once.
// ----------------------------------------------------------------------------
module angle_bias_kalman_update_core import abkf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    abkf_in_if.sink     i_in,
    abkf_out_if.source  o_out,
    abkf_cfg_if.sink    i_cfg
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_MUL_GO   = 8'b0000_0010,
        S_MUL_WAIT = 8'b0000_0100,
        S_WRAP     = 8'b0000_1000,
        S_GAIN     = 8'b0001_0000,
        S_DIV_GO   = 8'b0010_0000,
        S_DIV_WAIT = 8'b0100_0000,
        S_OUT      = 8'b1000_0000
    } t_state;

    typedef enum logic [3:0] {
        MOP_ANG, MOP_DTP11, MOP_DTT, MOP_DTQB, MOP_K0Y,
        MOP_K1Y, MOP_K1P00, MOP_K1P01, MOP_K0P00, MOP_K0P01
    } t_mop;

    localparam int WRAP_TOP = 4;
    localparam int WCNT_W   = $clog2(WRAP_TOP + 1);
    localparam int WRAP_OFS = ANG_FULL * (2 ** WRAP_TOP);

    t_state r_state;
    t_mop   r_step;
    logic [NOISE_W-1:0]       r_qa, r_qb, r_r;
    logic signed [ANG_W-1:0]  r_meas;
    logic signed [RATE_W-1:0] r_rate;
    logic [DT_W-1:0]          r_dt;
    logic signed [ANG_W-1:0]  r_angle;
    logic signed [BIAS_W-1:0] r_bias;
    logic signed [COV_W-1:0]  r_p00, r_p01, r_p10, r_p11, r_t;
    logic signed [K_W-1:0]    r_k0, r_k1;
    logic signed [Y_W-1:0]    r_y;
    logic signed [WX_W-1:0]   r_wx;
    logic [WCNT_W-1:0]        r_wcnt;
    logic                     r_dsel;
    logic                     r_oval;
    logic signed [ANG_W-1:0]  r_oang;
    logic signed [OBIAS_W-1:0] r_obias;

    t_mul_req               n_mreq;
    logic signed [K_W-1:0]  n_ma;
    logic signed [MB_W-1:0] n_mb;
    logic                   n_mdone;
    logic signed [MR_W-1:0] n_m;
    logic                   n_dstart;
    logic                   n_ddone;
    logic signed [K_W-1:0]  n_dq;
    logic signed [COV_W-1:0] n_dnum;

    logic signed [K_W-1:0]  n_dt_op;
    logic signed [29:0]     n_rdiff;
    logic signed [MR_W-1:0] n_asum;
    logic signed [WX_W-1:0] n_x;
    logic signed [WX_W-1:0] n_wx0;
    logic signed [WX_W-1:0] n_wsub;
    logic signed [WX_W-1:0] n_wv;
    logic signed [WX_W-1:0] n_wfin;
    logic signed [COV_W-1:0] n_t;
    logic signed [Y_W-1:0]  n_y0;
    logic signed [Y_W-1:0]  n_y;
    logic signed [DEN_W:0]  n_s;
    logic                   n_spos;
    logic                   n_in_acc;

    // ---------------- shared units ----------------
    assign n_dt_op = $signed({{(K_W-DT_W){1'b0}}, r_dt});
    assign n_rdiff = 30'(r_rate) - 30'(r_bias);

    always_comb begin
        n_ma = n_dt_op;
        n_mb = MB_W'(n_rdiff);
        case (r_step)
            MOP_ANG:   begin n_ma = n_dt_op; n_mb = MB_W'(n_rdiff); end
            MOP_DTP11: begin n_ma = n_dt_op; n_mb = r_p11; end
            MOP_DTT:   begin n_ma = n_dt_op; n_mb = r_t; end
            MOP_DTQB:  begin n_ma = n_dt_op; n_mb = $signed({{(MB_W-NOISE_W){1'b0}}, r_qb}); end
            MOP_K0Y:   begin n_ma = r_k0; n_mb = MB_W'(r_y); end
            MOP_K1Y:   begin n_ma = r_k1; n_mb = MB_W'(r_y); end
            MOP_K1P00: begin n_ma = r_k1; n_mb = r_p00; end
            MOP_K1P01: begin n_ma = r_k1; n_mb = r_p01; end
            MOP_K0P00: begin n_ma = r_k0; n_mb = r_p00; end
            MOP_K0P01: begin n_ma = r_k0; n_mb = r_p01; end
            default:   begin n_ma = n_dt_op; n_mb = MB_W'(n_rdiff); end
        endcase
    end

    assign n_mreq.start = (r_state == S_MUL_GO);
    assign n_mreq.shr30 = !(r_step == MOP_ANG || r_step == MOP_DTP11 ||
                            r_step == MOP_DTT || r_step == MOP_DTQB);

    abkf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (n_mreq),
        .i_a     (n_ma),
        .i_b     (n_mb),
        .o_done  (n_mdone),
        .o_res   (n_m)
    );

    assign n_s      = (DEN_W+1)'(r_p00) + $signed({{(DEN_W+1-NOISE_W){1'b0}}, r_r});
    assign n_spos   = !n_s[DEN_W] && (|n_s);
    assign n_dstart = (r_state == S_DIV_GO);
    assign n_dnum   = r_dsel ? r_p10 : r_p00;

    abkf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_dstart),
        .i_num   (n_dnum),
        .i_den   (n_s[DEN_W-1:0]),
        .o_done  (n_ddone),
        .o_quot  (n_dq)
    );

    // ---------------- datapath helpers ----------------
    assign n_asum = MR_W'(r_angle) + n_m;
    assign n_x    = n_asum[WX_W-1:0];
    // Negative sums are lifted by a multiple of 360 degrees before the
    // restoring reduction, which only handles non-negative values.
    assign n_wx0  = n_x[WX_W-1] ? n_x + WX_W'(WRAP_OFS) : n_x;
    assign n_wsub = WX_W'(ANG_FULL) << r_wcnt;
    assign n_wv   = (r_wx >= n_wsub) ? r_wx - n_wsub : r_wx;
    assign n_wfin = (n_wv > WX_W'(ANG_HALF)) ? n_wv - WX_W'(ANG_FULL) : n_wv;

    assign n_t = sat48(n_m - MR_W'(r_p01) - MR_W'(r_p10) +
                       $signed({{(MR_W-NOISE_W){1'b0}}, r_qa}));

    assign n_y0 = Y_W'(r_meas) - Y_W'(r_angle);
    always_comb begin
        if (n_y0 > Y_W'(ANG_HALF)) begin
            n_y = n_y0 - Y_W'(ANG_FULL);
        end else if (n_y0 < -Y_W'(ANG_HALF)) begin
            n_y = n_y0 + Y_W'(ANG_FULL);
        end else begin
            n_y = n_y0;
        end
    end

    assign n_in_acc = i_in.valid && i_in.ready;

    // ---------------- configuration ----------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qa <= QA_RST;
            r_qb <= QB_RST;
            r_r  <= R_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_ANGLE_NOISE: r_qa <= i_cfg.data;
                CFG_BIAS_NOISE:  r_qb <= i_cfg.data;
                CFG_MEAS_NOISE:  r_r  <= i_cfg.data;
                default:         ;
            endcase
        end
    end

    // ---------------- sequencer and filter state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= MOP_ANG;
            r_wcnt  <= '0;
            r_dsel  <= 1'b0;
            r_oval  <= 1'b0;
            r_angle <= '0;
            r_bias  <= '0;
            r_p00   <= '0;
            r_p01   <= '0;
            r_p10   <= '0;
            r_p11   <= '0;
        end else begin
            if (r_state == S_OUT && (!r_oval || o_out.ready)) begin
                r_oval <= 1'b1;
            end else if (o_out.valid && o_out.ready) begin
                r_oval <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (n_in_acc) begin
                        r_step  <= MOP_ANG;
                        r_state <= S_MUL_GO;
                    end
                end
                S_MUL_GO: begin
                    r_state <= S_MUL_WAIT;
                end
                S_MUL_WAIT: begin
                    if (n_mdone) begin
                        case (r_step)
                            MOP_ANG, MOP_K0Y: begin
                                r_wcnt  <= WCNT_W'(WRAP_TOP);
                                r_state <= S_WRAP;
                            end
                            MOP_DTP11: begin
                                r_p01   <= sat48(MR_W'(r_p01) - n_m);
                                r_p10   <= sat48(MR_W'(r_p10) - n_m);
                                r_step  <= MOP_DTT;
                                r_state <= S_MUL_GO;
                            end
                            MOP_DTT: begin
                                r_p00   <= sat48(MR_W'(r_p00) + n_m);
                                r_step  <= MOP_DTQB;
                                r_state <= S_MUL_GO;
                            end
                            MOP_DTQB: begin
                                r_p11   <= sat48(MR_W'(r_p11) + n_m);
                                r_state <= S_GAIN;
                            end
                            MOP_K1Y: begin
                                r_bias  <= clamp_bias(MR_W'(r_bias) + n_m);
                                r_step  <= MOP_K1P00;
                                r_state <= S_MUL_GO;
                            end
                            MOP_K1P00: begin
                                r_p10   <= sat48(MR_W'(r_p10) - n_m);
                                r_step  <= MOP_K1P01;
                                r_state <= S_MUL_GO;
                            end
                            MOP_K1P01: begin
                                r_p11   <= sat48(MR_W'(r_p11) - n_m);
                                r_step  <= MOP_K0P00;
                                r_state <= S_MUL_GO;
                            end
                            MOP_K0P00: begin
                                r_p00   <= sat48(MR_W'(r_p00) - n_m);
                                r_step  <= MOP_K0P01;
                                r_state <= S_MUL_GO;
                            end
                            MOP_K0P01: begin
                                r_p01   <= sat48(MR_W'(r_p01) - n_m);
                                r_state <= S_OUT;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_WRAP: begin
                    if (r_wcnt == '0) begin
                        r_angle <= n_wfin[ANG_W-1:0];
                        r_state <= S_MUL_GO;
                        r_step  <= (r_step == MOP_ANG) ? MOP_DTP11 : MOP_K1Y;
                    end else begin
                        r_wcnt <= r_wcnt - WCNT_W'(1);
                    end
                end
                S_GAIN: begin
                    // A non-positive innovation variance gives zero gains,
                    // and the correction then leaves everything unchanged.
                    if (n_spos) begin
                        r_dsel  <= 1'b0;
                        r_state <= S_DIV_GO;
                    end else begin
                        r_step  <= MOP_K0Y;
                        r_state <= S_MUL_GO;
                    end
                end
                S_DIV_GO: begin
                    r_state <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (n_ddone) begin
                        if (!r_dsel) begin
                            r_dsel  <= 1'b1;
                            r_state <= S_DIV_GO;
                        end else begin
                            r_step  <= MOP_K0Y;
                            r_state <= S_MUL_GO;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_oval || o_out.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && n_in_acc) begin
            r_meas <= i_in.measured_angle;
            r_rate <= i_in.rate;
            r_dt   <= (i_in.time_step > DT_W'(DT_MAX)) ? DT_W'(DT_MAX) : i_in.time_step;
        end
        if (r_state == S_MUL_WAIT && n_mdone) begin
            if (r_step == MOP_ANG || r_step == MOP_K0Y) begin
                r_wx <= n_wx0;
            end
            if (r_step == MOP_DTP11) begin
                r_t <= n_t;
            end
        end
        if (r_state == S_WRAP) begin
            r_wx <= n_wv;
        end
        if (r_state == S_GAIN) begin
            r_y <= n_y;
            if (!n_spos) begin
                r_k0 <= '0;
                r_k1 <= '0;
            end
        end
        if (r_state == S_DIV_WAIT && n_ddone) begin
            if (!r_dsel) begin
                r_k0 <= n_dq;
            end else begin
                r_k1 <= n_dq;
            end
        end
        if (r_state == S_OUT && (!r_oval || o_out.ready)) begin
            r_oang  <= r_angle;
            r_obias <= r_bias[OBIAS_W-1:0];
        end
    end

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = r_oval;
    assign o_out.angle_estimate = r_oang;
    assign o_out.bias_estimate  = r_obias;

endmodule

FILE: hdl/abkf_mul.sv
// ----------------------------------------------------------------------------
// abkf_mul
// Shared multiplier: 33-bit signed by 48-bit signed in two partial products,
// then a round-half-up right shift by 16 or 30.
// ----------------------------------------------------------------------------
module abkf_mul import abkf_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_mul_req               i_req,
    input  logic signed [K_W-1:0]  i_a,
    input  logic signed [MB_W-1:0] i_b,
    output logic                   o_done,
    output logic signed [MR_W-1:0] o_res
);

    localparam int HALF_W = MB_W / 2;
    localparam int LO_W   = K_W + HALF_W + 1;
    localparam int HI_W   = K_W + HALF_W;
    localparam int P_W    = K_W + MB_W;
    localparam logic signed [P_W-1:0] RND16 = P_W'(1) <<< 15;
    localparam logic signed [P_W-1:0] RND30 = P_W'(1) <<< 29;

    logic [2:0]              r_ph;
    logic                    r_done;
    logic signed [K_W-1:0]   r_a;
    logic signed [MB_W-1:0]  r_b;
    logic                    r_sh30;
    logic signed [LO_W-1:0]  r_lo;
    logic signed [P_W-1:0]   r_prod;
    logic signed [MR_W-1:0]  r_res;

    logic signed [LO_W-1:0]  n_lo;
    logic signed [HI_W-1:0]  n_hi;
    logic signed [P_W-1:0]   n_prod;
    logic signed [P_W-1:0]   n_rnd;
    logic signed [P_W-1:0]   n_shr;

    assign n_lo   = r_a * $signed({1'b0, r_b[HALF_W-1:0]});
    assign n_hi   = r_a * $signed(r_b[MB_W-1:HALF_W]);
    assign n_prod = (P_W'(n_hi) <<< HALF_W) + P_W'(r_lo);
    assign n_rnd  = r_prod + (r_sh30 ? RND30 : RND16);
    assign n_shr  = r_sh30 ? (n_rnd >>> 30) : (n_rnd >>> 16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= '0;
            r_done <= 1'b0;
        end else begin
            r_ph   <= {r_ph[1:0], i_req.start};
            r_done <= r_ph[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a    <= i_a;
            r_b    <= i_b;
            r_sh30 <= i_req.shr30;
        end
        if (r_ph[0]) begin
            r_lo <= n_lo;
        end
        if (r_ph[1]) begin
            r_prod <= n_prod;
        end
        if (r_ph[2]) begin
            r_res <= n_shr[MR_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

FILE: hdl/abkf_div.sv
// ----------------------------------------------------------------------------
// abkf_div
// Radix-2 restoring divider for the gains: num * 2^30 / den, truncated toward
// zero, magnitude saturated at 2^31. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module abkf_div import abkf_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [COV_W-1:0] i_num,
    input  logic [DEN_W-1:0]        i_den,
    output logic                    o_done,
    output logic signed [K_W-1:0]   o_quot
);

    localparam int DIV_STEPS = 30;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);
    localparam int Q_W       = DIV_STEPS + 1;

    logic               r_init;
    logic               r_run;
    logic               r_fin;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [DEN_W-1:0]   r_mag;
    logic [DEN_W-1:0]   r_d;
    logic [DEN_W-1:0]   r_rem;
    logic               r_neg;
    logic               r_sat;
    logic [Q_W-1:0]     r_q;
    logic signed [K_W-1:0] r_quot;

    logic [COV_W-1:0]   n_mag;
    logic               n_over;
    logic               n_ge0;
    logic [DEN_W:0]     n_rem2;
    logic               n_ge;
    logic [K_W-2:0]     n_kmag;
    logic signed [K_W-1:0] n_quot;

    assign n_mag  = i_num[COV_W-1] ? COV_W'(-i_num) : COV_W'(i_num);
    assign n_over = {1'b0, r_mag} >= {r_d, 1'b0};
    assign n_ge0  = r_mag >= r_d;
    assign n_rem2 = {r_rem, 1'b0};
    assign n_ge   = n_rem2 >= {1'b0, r_d};
    assign n_kmag = r_sat ? {1'b1, {(K_W-2){1'b0}}} : {1'b0, r_q};
    assign n_quot = r_neg ? -$signed({1'b0, n_kmag}) : $signed({1'b0, n_kmag});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= 1'b0;
            r_run  <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_fin;
            r_init <= i_start;
            r_fin  <= (r_init && n_over) || (r_run && r_cnt == CNT_W'(1));
            if (r_init) begin
                if (!n_over) begin
                    r_run <= 1'b1;
                    r_cnt <= CNT_W'(DIV_STEPS);
                end
            end else if (r_run) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_run <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag <= {1'b0, n_mag};
            r_d   <= i_den;
            r_neg <= i_num[COV_W-1];
        end
        if (r_init) begin
            r_sat <= n_over;
            r_q   <= {{(Q_W-1){1'b0}}, n_ge0};
            r_rem <= n_ge0 ? r_mag - r_d : r_mag;
        end
        if (r_run) begin
            r_rem <= n_ge ? DEN_W'(n_rem2 - {1'b0, r_d}) : DEN_W'(n_rem2);
            r_q   <= {r_q[Q_W-2:0], n_ge};
        end
        if (r_fin) begin
            r_quot <= n_quot;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

FILE: hdl/abkf_checker.sv
// ----------------------------------------------------------------------------
// abkf_checker
// Port-level checks of the Kalman update core, bound to the top level.
// ----------------------------------------------------------------------------
`include "angle_bias_kalman_update_core_macros.svh"

module abkf_checker import abkf_pkg::*; (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic signed [ANG_W-1:0]   i_out_angle,
    input logic signed [OBIAS_W-1:0] i_out_bias
);

    // The block works on one item at a time.
    `ABKF_ASSERT_NEXT(a_busy_after_item, i_in_valid && i_in_ready, !i_in_ready, "input ready right after an item")
    `ABKF_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_angle) && $stable(i_out_bias), "stalled result changed")
    `ABKF_ASSERT_SAME(a_angle_range, i_out_valid, i_out_angle > -ANG_HALF && i_out_angle <= ANG_HALF, "angle out of range")
    `ABKF_ASSERT_SAME(a_bias_range, i_out_valid, i_out_bias >= -BIAS_MAX && i_out_bias <= BIAS_MAX, "bias out of range")

endmodule

bind angle_bias_kalman_update_core abkf_checker u_abkf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_angle (o_out.angle_estimate),
    .i_out_bias  (o_out.bias_estimate)
);

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// Kalman update core testbench
// Drives measurement items and register writes into the angle/bias filter,
// predicts every result with a fixed-point model of its own and compares the
// angle and bias of each result in order, under several idling patterns.
// ----------------------------------------------------------------------------
module tb;
    import abkf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint COV_HI = 64'sd140737488355327;
    localparam longint COV_LO = -64'sd140737488355328;
    localparam int WATCHDOG = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    abkf_in_if  in_ch();
    abkf_out_if out_ch();
    abkf_cfg_if cfg_ch();

    angle_bias_kalman_update_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    always #1 i_clk = ~i_clk;

    typedef struct {
        logic signed [ANG_W-1:0]   angle;
        logic signed [OBIAS_W-1:0] bias;
    } t_estimate;

    t_estimate pending_estimates[$];

    // Filter state mirrored by the predictor.
    longint filt_angle, filt_bias;
    longint filt_cov[4];
    longint noise_angle, noise_bias, noise_meas;

    int errors = 0;
    int items_sent = 0;
    int results_seen = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;

    function automatic longint clip(longint x, longint lo, longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function automatic longint sat_cov(longint x);
        return clip(x, COV_LO, COV_HI);
    endfunction

    // Arithmetic shift right floors, so adding half first rounds half up.
    function automatic longint scaled_product(longint a, longint b, int n);
        longint hi, lo;
        hi = b >>> n;
        lo = b - (hi <<< n);
        return a * hi + ((a * lo + (64'sd1 <<< (n - 1))) >>> n);
    endfunction

    function automatic longint wrap_deg(longint x);
        longint r;
        r = x % ANG_FULL;
        if (r < 0) r += ANG_FULL;
        if (r > ANG_HALF) r -= ANG_FULL;
        return r;
    endfunction

    function automatic longint gain_of(longint num, longint den);
        longint mag, q, rem, frac, k;
        mag = num < 0 ? -num : num;
        q = mag / den;
        rem = mag % den;
        frac = 0;
        if (q >= 2) begin
            k = 64'sd2147483648;
        end else begin
            for (int i = 0; i < 30; i++) begin
                rem = rem <<< 1;
                frac = frac <<< 1;
                if (rem >= den) begin
                    rem -= den;
                    frac |= 1;
                end
            end
            k = (q <<< 30) | frac;
        end
        return num < 0 ? -k : k;
    endfunction

    function automatic void predict_estimate(logic signed [ANG_W-1:0] meas_in,
                                             logic signed [RATE_W-1:0] rate_in,
                                             logic [DT_W-1:0] dt_in);
        longint meas, rate, dt, p00, p01, p10, p11, t, s, k0, k1, y;
        t_estimate e;
        meas = meas_in;
        rate = rate_in;
        dt = dt_in > DT_MAX ? DT_MAX : dt_in;
        filt_angle = wrap_deg(filt_angle + scaled_product(dt, rate - filt_bias, 16));
        p00 = filt_cov[0];
        p01 = filt_cov[1];
        p10 = filt_cov[2];
        p11 = filt_cov[3];
        t = sat_cov(scaled_product(dt, p11, 16) - p01 - p10 + noise_angle);
        p00 = sat_cov(p00 + scaled_product(dt, t, 16));
        p01 = sat_cov(p01 - scaled_product(dt, p11, 16));
        p10 = sat_cov(p10 - scaled_product(dt, p11, 16));
        p11 = sat_cov(p11 + scaled_product(dt, noise_bias, 16));
        s = p00 + noise_meas;
        if (s > 0) begin
            k0 = gain_of(p00, s);
            k1 = gain_of(p10, s);
        end else begin
            k0 = 0;
            k1 = 0;
        end
        y = meas - filt_angle;
        if (y > ANG_HALF) y -= ANG_FULL;
        else if (y < -ANG_HALF) y += ANG_FULL;
        filt_angle = wrap_deg(filt_angle + scaled_product(k0, y, 30));
        filt_bias = clip(filt_bias + scaled_product(k1, y, 30), -BIAS_MAX, BIAS_MAX);
        filt_cov[0] = sat_cov(p00 - scaled_product(k0, p00, 30));
        filt_cov[1] = sat_cov(p01 - scaled_product(k0, p01, 30));
        filt_cov[2] = sat_cov(p10 - scaled_product(k1, p00, 30));
        filt_cov[3] = sat_cov(p11 - scaled_product(k1, p01, 30));
        e.angle = filt_angle[ANG_W-1:0];
        e.bias = filt_bias[OBIAS_W-1:0];
        pending_estimates.push_back(e);
    endfunction

    task automatic send_measurement(logic signed [ANG_W-1:0] meas,
                                    logic signed [RATE_W-1:0] rate,
                                    logic [DT_W-1:0] dt);
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.measured_angle <= meas;
        in_ch.rate <= rate;
        in_ch.time_step <= dt;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_estimate(meas, rate, dt);
        items_sent++;
        in_ch.valid <= 1'b0;
        // The block is busy right after an item, so this cycle costs nothing.
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (pending_estimates.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_noise(logic [CIDX_W-1:0] idx, logic [NOISE_W-1:0] value);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_ANGLE_NOISE: noise_angle = value;
            CFG_BIAS_NOISE:  noise_bias = value;
            CFG_MEAS_NOISE:  noise_meas = value;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    function automatic logic signed [ANG_W-1:0] any_angle();
        return ANG_W'($signed($urandom_range(2 * ANG_HALF)) - ANG_HALF);
    endfunction

    function automatic logic signed [RATE_W-1:0] any_rate();
        return RATE_W'($signed($urandom_range(2 * BIAS_MAX)) - BIAS_MAX);
    endfunction

    // Result checker.
    always @(posedge i_clk) begin
        t_estimate e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            results_seen++;
            if (pending_estimates.size() == 0) begin
                $display("%0t: unexpected result angle=%0d bias=%0d", $time,
                         out_ch.angle_estimate, out_ch.bias_estimate);
                errors++;
            end else begin
                e = pending_estimates.pop_front();
                if (out_ch.angle_estimate !== e.angle) begin
                    $display("%0t: angle expected %0d actual %0d", $time, e.angle,
                             out_ch.angle_estimate);
                    errors++;
                end
                if (out_ch.bias_estimate !== e.bias) begin
                    $display("%0t: bias expected %0d actual %0d", $time, e.bias,
                             out_ch.bias_estimate);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog on cycles without any accepted item, result or register write.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic test_directed();
        logic signed [ANG_W-1:0] a_hi, a_lo;
        logic signed [RATE_W-1:0] r_hi, r_lo;
        a_hi = ANG_HALF;
        a_lo = -ANG_HALF;
        r_hi = BIAS_MAX;
        r_lo = -BIAS_MAX;
        send_measurement('0, '0, 17'd0);             // zero time step
        send_measurement(a_hi, r_hi, 17'd65536);
        send_measurement(a_lo, r_lo, 17'd65536);
        send_measurement(a_hi, r_hi, 17'h1FFFF);     // long time step saturates
        send_measurement(a_lo, r_hi, 17'd65537);
        send_measurement(a_hi, '0, 17'd1);
        send_measurement(ANG_W'(-ANG_HALF + 1), r_lo, 17'd655);
        // Measurements outside the nominal range, used as given.
        send_measurement({1'b0, {(ANG_W-1){1'b1}}}, {1'b0, {(RATE_W-1){1'b1}}}, 17'd32768);
        send_measurement({1'b1, {(ANG_W-1){1'b0}}}, {1'b1, {(RATE_W-1){1'b0}}}, 17'd32768);
        send_measurement(ANG_W'(ANG_HALF - 1), r_hi, 17'h10000);
        // Drive the bias into saturation with a long run of big errors.
        for (int i = 0; i < 8; i++) send_measurement(i[0] ? a_hi : a_lo, r_hi, 17'd65536);
        send_measurement('1, '1, 17'd1000);
    endtask

    task automatic test_registers();
        write_noise(CFG_ANGLE_NOISE, '1);
        write_noise(CFG_BIAS_NOISE, '1);
        write_noise(CFG_MEAS_NOISE, NOISE_W'(1));
        for (int i = 0; i < 6; i++) send_measurement(any_angle(), any_rate(), 17'd65536);
        write_noise(CFG_ANGLE_NOISE, '0);
        write_noise(CFG_BIAS_NOISE, '0);
        write_noise(CFG_MEAS_NOISE, '1);
        for (int i = 0; i < 6; i++) send_measurement(any_angle(), any_rate(), 17'd65536);
        write_noise(CFG_ANGLE_NOISE, QA_RST);
        write_noise(CFG_BIAS_NOISE, QB_RST);
        write_noise(CFG_MEAS_NOISE, R_RST);
    endtask

    task automatic test_random(int count, int idle_pct, int stall_pct);
        logic [DT_W-1:0] dt;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++) begin
            // Mostly typical sample intervals, with the odd extreme.
            case ($urandom_range(9))
                0: dt = DT_W'($urandom);
                1: dt = DT_W'($urandom_range(65536));
                default: dt = DT_W'($urandom_range(1500, 300));
            endcase
            if ($urandom_range(3) == 0) send_measurement(ANG_W'($urandom), RATE_W'($urandom), dt);
            else send_measurement(any_angle(), RATE_W'($signed($urandom_range(2000000)) - 1000000), dt);
            if (i == count / 2) wait_drained();
        end
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.measured_angle = '0;
        in_ch.rate = '0;
        in_ch.time_step = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        out_ch.ready = 1'b1;
        filt_angle = 0;
        filt_bias = 0;
        foreach (filt_cov[i]) filt_cov[i] = 0;
        noise_angle = QA_RST;
        noise_bias = QB_RST;
        noise_meas = R_RST;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_registers();
        test_random(300, 0, 0);
        test_random(300, 70, 0);
        write_noise(CFG_MEAS_NOISE, NOISE_W'($urandom_range(1 << 20, 1)));
        test_random(300, 0, 70);
        write_noise(CFG_MEAS_NOISE, NOISE_W'($urandom));
        write_noise(CFG_ANGLE_NOISE, NOISE_W'($urandom));
        write_noise(CFG_BIAS_NOISE, NOISE_W'($urandom));
        test_random(300, 15, 15);

        wait_drained();
        repeat (300) @(posedge i_clk);
        $display("Sent %0d items, checked %0d results across four idling phases", items_sent,
                 results_seen);
        $display("and thirteen register writes including both extremes.");
        if (errors == 0 && pending_estimates.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
